### design/utfbd_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 BMP decoder.
package utfbd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned UnitW  = 16;
  localparam int unsigned PointW = 21;
  localparam int unsigned LeftW  = 2;

  localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Code = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Code = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Code = 8'hF0;

  localparam logic [LeftW-1:0] LeftNone = 2'd0;
  localparam logic [LeftW-1:0] LeftOne  = 2'd1;
  localparam logic [LeftW-1:0] LeftTwo  = 2'd2;
  localparam logic [LeftW-1:0] LeftThree = 2'd3;

  typedef struct packed {
    logic              pt_valid;
    logic [UnitW-1:0]  pt_value;
    logic              term;
    logic [PointW-1:0] next_partial;
    logic [LeftW-1:0]  next_left;
  } dec_res_t;

endpackage

### design/utfbd_decode.sv
// Combinational step: one byte against the held sequence state.
module utfbd_decode import utfbd_pkg::*; (
  input  logic [ByteW-1:0]  data_byte_i,
  input  logic              has_byte_i,
  input  logic              end_of_string_i,
  input  logic [PointW-1:0] partial_i,
  input  logic [LeftW-1:0]  left_i,
  output dec_res_t          res_o
);

  logic [PointW-1:0] np;
  logic [LeftW-1:0]  nl;
  logic              emit;
  logic [PointW-1:0] ep;

  always_comb begin
    np   = partial_i;
    nl   = left_i;
    emit = 1'b0;
    ep   = '0;
    if (has_byte_i) begin
      if (left_i != LeftNone) begin
        np = {partial_i[PointW-7:0], data_byte_i[5:0]};
        nl = left_i - LeftOne;
        if (nl == LeftNone) begin
          emit = 1'b1;
          ep   = np;
          np   = '0;
        end
      end else if ((data_byte_i & Lead2Mask) == Lead2Code) begin
        np = {{(PointW-5){1'b0}}, data_byte_i[4:0]};
        nl = LeftOne;
      end else if ((data_byte_i & Lead3Mask) == Lead3Code) begin
        np = {{(PointW-4){1'b0}}, data_byte_i[3:0]};
        nl = LeftTwo;
      end else if ((data_byte_i & Lead4Mask) == Lead4Code) begin
        np = {{(PointW-3){1'b0}}, data_byte_i[2:0]};
        nl = LeftThree;
      end else begin
        emit = 1'b1;
        ep   = {{(PointW-ByteW){1'b0}}, data_byte_i};
      end
    end
    if (end_of_string_i) begin
      if (nl != LeftNone) begin
        emit = 1'b1;
        ep   = np;
      end
      np = '0;
      nl = LeftNone;
    end
    res_o.pt_valid     = emit && (ep != '0) && (ep[PointW-1:UnitW] == '0);
    res_o.pt_value     = ep[UnitW-1:0];
    res_o.term         = end_of_string_i;
    res_o.next_partial = np;
    res_o.next_left    = nl;
  end

endmodule

### design/utfbd_out_reg.sv
// Result register for the master-side stream.
module utfbd_out_reg import utfbd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic [UnitW-1:0] unit_i,
  input  logic             last_i,
  output logic             free_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [UnitW-1:0] m_axis_tdata,
  output logic             m_axis_tlast
);

  logic             valid_q;
  logic [UnitW-1:0] data_q;
  logic             last_q;

  assign free_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      data_q <= unit_i;
      last_q <= last_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tlast  = last_q;

endmodule

### design/utf8_to_utf16_bmp_decoder_core.sv
// Top level: UTF-8 byte stream in, UTF-16 BMP code units out.
// An input transfer is held in the input register and decoded combinationally into the output register.
// Throughput: 1 byte per cycle while the output register is free; an item giving a code unit
// and a terminator holds the input register until both are loaded (one output register, one unit a cycle).
// Reset (rst_ni low, asynchronous) empties both registers and clears the sequence state.
module utf8_to_utf16_bmp_decoder_core import utfbd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,  // [7:0] data_byte
  input  logic             s_axis_tuser,  // [0] has_byte
  input  logic             s_axis_tlast,  // end_of_string
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // [15:0] code_unit
  output logic             m_axis_tlast   // is_terminator
);

  logic              in_valid_q;
  logic [ByteW-1:0]  in_byte_q;
  logic              in_has_q;
  logic              in_last_q;
  logic [PointW-1:0] partial_q;
  logic [LeftW-1:0]  left_q;
  logic              pt_sent_q;
  logic              pt_sent_d;
  dec_res_t          dec;
  logic              out_free;
  logic              out_load;
  logic [UnitW-1:0]  out_unit;
  logic              out_last;
  logic              consume;

  utfbd_decode u_decode (
    .data_byte_i     (in_byte_q),
    .has_byte_i      (in_has_q),
    .end_of_string_i (in_last_q),
    .partial_i       (partial_q),
    .left_i          (left_q),
    .res_o           (dec)
  );

  always_comb begin
    out_load  = 1'b0;
    out_unit  = '0;
    out_last  = 1'b0;
    consume   = 1'b0;
    pt_sent_d = pt_sent_q;
    if (in_valid_q) begin
      if (dec.pt_valid && !pt_sent_q) begin
        if (out_free) begin
          out_load = 1'b1;
          out_unit = dec.pt_value;
          if (dec.term) begin
            pt_sent_d = 1'b1;
          end else begin
            consume = 1'b1;
          end
        end
      end else if (dec.term) begin
        if (out_free) begin
          out_load  = 1'b1;
          out_last  = 1'b1;
          consume   = 1'b1;
          pt_sent_d = 1'b0;
        end
      end else begin
        consume = 1'b1;
      end
    end
  end

  assign s_axis_tready = !in_valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      partial_q  <= '0;
      left_q     <= LeftNone;
      pt_sent_q  <= 1'b0;
    end else begin
      pt_sent_q <= pt_sent_d;
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (consume) begin
        partial_q <= dec.next_partial;
        left_q    <= dec.next_left;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_has_q  <= s_axis_tuser;
      in_last_q <= s_axis_tlast;
    end
  end

  utfbd_out_reg u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (out_load),
    .unit_i        (out_unit),
    .last_i        (out_last),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### bench/tb_utf8_to_utf16_bmp_decoder_core.sv
// Testbench for the UTF-8 to UTF-16 BMP decoder core: directed table, random strings, predictor.
module tb_utf8_to_utf16_bmp_decoder_core;
  import utfbd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [UnitW-1:0] cu;
    logic             term;
  } unit_t;

  typedef struct packed {
    logic [ByteW-1:0] b;
    logic             has;
    logic             eos;
    logic             fixed;
    logic [1:0]       n;
    unit_t            e0;
    unit_t            e1;
  } row_t;

  localparam unit_t NoUnit   = '{16'h0000, 1'b0};
  localparam unit_t TermUnit = '{16'h0000, 1'b1};
  localparam int unsigned RandItems = 550;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata;  // [7:0] data_byte
  logic             s_axis_tuser;  // [0] has_byte
  logic             s_axis_tlast;  // end_of_string
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [15:0]      m_axis_tdata;  // [15:0] code_unit
  logic             m_axis_tlast;  // is_terminator

  logic [PointW-1:0] seq_point;
  logic [LeftW-1:0]  seq_left;
  unit_t             step_units[$];
  unit_t             want_units[$];
  unit_t             got_want;
  logic [ByteW-1:0]  str_bytes[$];
  int                burst_left;
  int                items_sent;
  int                next_pause;
  int                errors = 0;
  logic [7:0]        stall_cnt = '0;
  logic [1:0]        stall_mode = '0;

  row_t dir_rows [26] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, 2'd1, TermUnit, NoUnit},
    '{8'h00, 1'b1, 1'b0, 1'b1, 2'd0, NoUnit, NoUnit},
    '{8'h7F, 1'b1, 1'b0, 1'b1, 2'd1, '{16'h007F, 1'b0}, NoUnit},
    '{8'h80, 1'b1, 1'b0, 1'b1, 2'd1, '{16'h0080, 1'b0}, NoUnit},
    '{8'hF8, 1'b1, 1'b0, 1'b1, 2'd1, '{16'h00F8, 1'b0}, NoUnit},
    '{8'hFF, 1'b1, 1'b0, 1'b1, 2'd1, '{16'h00FF, 1'b0}, NoUnit},
    '{8'hC2, 1'b1, 1'b0, 1'b1, 2'd0, NoUnit, NoUnit},
    '{8'hA9, 1'b1, 1'b0, 1'b0, 2'd0, NoUnit, NoUnit},
    '{8'hE2, 1'b1, 1'b0, 1'b1, 2'd0, NoUnit, NoUnit},
    '{8'h3C, 1'b0, 1'b0, 1'b1, 2'd0, NoUnit, NoUnit},
    '{8'h82, 1'b1, 1'b0, 1'b0, 2'd0, NoUnit, NoUnit},
    '{8'hAC, 1'b1, 1'b0, 1'b0, 2'd0, NoUnit, NoUnit},
    '{8'hEF, 1'b1, 1'b0, 1'b1, 2'd0, NoUnit, NoUnit},
    '{8'hBF, 1'b1, 1'b0, 1'b0, 2'd0, NoUnit, NoUnit},
    '{8'hBF, 1'b1, 1'b0, 1'b0, 2'd0, NoUnit, NoUnit},
    '{8'hF0, 1'b1, 1'b0, 1'b1, 2'd0, NoUnit, NoUnit},
    '{8'h9F, 1'b1, 1'b0, 1'b0, 2'd0, NoUnit, NoUnit},
    '{8'h98, 1'b1, 1'b0, 1'b0, 2'd0, NoUnit, NoUnit},
    '{8'h80, 1'b1, 1'b0, 1'b0, 2'd0, NoUnit, NoUnit},
    '{8'hC0, 1'b1, 1'b0, 1'b1, 2'd0, NoUnit, NoUnit},
    '{8'h41, 1'b1, 1'b0, 1'b0, 2'd0, NoUnit, NoUnit},
    '{8'hE2, 1'b1, 1'b0, 1'b1, 2'd0, NoUnit, NoUnit},
    '{8'h82, 1'b1, 1'b1, 1'b0, 2'd0, NoUnit, NoUnit},
    '{8'hF7, 1'b1, 1'b0, 1'b1, 2'd0, NoUnit, NoUnit},
    '{8'h5A, 1'b0, 1'b1, 1'b0, 2'd0, NoUnit, NoUnit},
    '{8'h41, 1'b1, 1'b1, 1'b1, 2'd2, '{16'h0041, 1'b0}, TermUnit}
  };

  utf8_to_utf16_bmp_decoder_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb_utf8_to_utf16_bmp_decoder_core NOT OK");
    $finish;
  end

  task automatic add_step(input unit_t u);
    step_units = {step_units, u};
  endtask

  task automatic add_want(input unit_t u);
    want_units = {want_units, u};
  endtask

  task automatic add_byte(input logic [ByteW-1:0] v);
    str_bytes = {str_bytes, v};
  endtask

  task automatic post_point(input logic [PointW-1:0] cp);
    if (cp != '0 && cp <= 21'h00FFFF) begin
      add_step('{cp[UnitW-1:0], 1'b0});
    end
  endtask

  task automatic decode_byte(input logic [ByteW-1:0] b, input logic has, input logic eos);
    step_units.delete();
    if (has) begin
      if (seq_left != LeftNone) begin
        seq_point = {seq_point[PointW-7:0], b[5:0]};
        seq_left  = seq_left - 1'b1;
        if (seq_left == LeftNone) begin
          post_point(seq_point);
          seq_point = '0;
        end
      end else if ((b & Lead2Mask) == Lead2Code) begin
        seq_point = {16'd0, b[4:0]};
        seq_left  = LeftOne;
      end else if ((b & Lead3Mask) == Lead3Code) begin
        seq_point = {17'd0, b[3:0]};
        seq_left  = LeftTwo;
      end else if ((b & Lead4Mask) == Lead4Code) begin
        seq_point = {18'd0, b[2:0]};
        seq_left  = LeftThree;
      end else begin
        post_point({13'd0, b});
      end
    end
    if (eos) begin
      if (seq_left != LeftNone) post_point(seq_point);
      add_step(TermUnit);
      seq_point = '0;
      seq_left  = LeftNone;
    end
  endtask

  task automatic send_item(input logic [ByteW-1:0] b, input logic has, input logic eos,
                           input logic fixed, input logic [1:0] n,
                           input unit_t e0, input unit_t e1);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= has;
    s_axis_tlast  <= eos;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    decode_byte(b, has, eos);
    if (fixed) begin
      if (n > 2'd0) add_want(e0);
      if (n > 2'd1) add_want(e1);
    end else begin
      foreach (step_units[k]) add_want(step_units[k]);
    end
    @(posedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
    end
  endtask

  task automatic send_byte(input logic [ByteW-1:0] b, input logic has, input logic eos);
    send_item(b, has, eos, 1'b0, 2'd0, NoUnit, NoUnit);
  endtask

  task automatic wait_idle();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (want_units.size() != 0) @(posedge clk_i);
  endtask

  task automatic build_string();
    int          n_chars;
    int          kind;
    int          extra;
    logic [20:0] cp;
    str_bytes.delete();
    n_chars = $urandom_range(0, 10);
    for (int i = 0; i < n_chars; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        add_byte(8'($urandom_range(0, 127)));
      end else if (kind < 52) begin
        cp = 21'($urandom_range(12'h080, 12'h7FF));
        add_byte({3'b110, cp[10:6]});
        add_byte({2'b10, cp[5:0]});
      end else if (kind < 74) begin
        cp = 21'($urandom_range(16'h0800, 16'hFFFF));
        add_byte({4'b1110, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end else if (kind < 84) begin
        cp = ($urandom_range(0, 3) == 0) ? 21'($urandom_range(0, 16'hFFFF))
                                         : 21'($urandom_range(21'h10000, 21'h1FFFFF));
        add_byte({5'b11110, cp[20:18]});
        add_byte({2'b10, cp[17:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end else if (kind < 92) begin
        add_byte(8'($urandom));
      end else begin
        add_byte(8'($urandom_range(8'hC0, 8'hF7)));
        extra = $urandom_range(0, 2);
        for (int j = 0; j < extra; j++) add_byte(8'($urandom));
      end
    end
  endtask

  task automatic send_string();
    logic tail_eos;
    logic eos;
    tail_eos = ($urandom_range(0, 3) != 0);
    foreach (str_bytes[i]) begin
      if ($urandom_range(0, 19) == 0) send_byte(8'($urandom), 1'b0, 1'b0);
      eos = tail_eos && (i == str_bytes.size() - 1);
      send_byte(str_bytes[i], 1'b1, eos);
      items_sent++;
    end
    if (!tail_eos || str_bytes.size() == 0) begin
      send_byte(8'($urandom), 1'b0, 1'b1);
      items_sent++;
    end
  endtask

  always @(posedge clk_i) begin
    stall_cnt <= stall_cnt + 1'b1;
    if (stall_cnt[5:0] == 6'd0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2'd2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (stall_cnt[2:0] < 3'd3);
    endcase
  end

  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (want_units.size() == 0) begin
        $display("%0t: unexpected transfer code_unit %h is_terminator %b",
                 $time, m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        got_want = want_units.pop_front();
        if (m_axis_tdata !== got_want.cu) begin
          $display("%0t: code_unit expected %h actual %h", $time, got_want.cu, m_axis_tdata);
          errors++;
        end
        if (m_axis_tlast !== got_want.term) begin
          $display("%0t: is_terminator expected %b actual %b",
                   $time, got_want.term, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    seq_point     = '0;
    seq_left      = LeftNone;
    burst_left    = 0;
    items_sent    = 0;
    next_pause    = 180;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].b, dir_rows[i].has, dir_rows[i].eos, dir_rows[i].fixed,
                dir_rows[i].n, dir_rows[i].e0, dir_rows[i].e1);
    end
    wait_idle();
    while (items_sent < RandItems) begin
      build_string();
      send_string();
      if (items_sent >= next_pause) begin
        wait_idle();
        next_pause += 180;
      end
    end
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (errors == 0 && want_units.size() == 0) begin
      $display("tb_utf8_to_utf16_bmp_decoder_core OK");
    end else begin
      $display("tb_utf8_to_utf16_bmp_decoder_core NOT OK");
    end
    $finish;
  end

endmodule
